/* rtl/core/bernstein_basis_evaluator_core_defines.svh */
// Assertion macros shared by the Bernstein basis evaluator RTL
`ifndef BERNSTEIN_BASIS_EVALUATOR_CORE_DEFINES_SVH
`define BERNSTEIN_BASIS_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BBE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

/* rtl/core/bbe_pkg.sv */
// Types and constants of the Bernstein basis evaluator
package bbe_pkg;

    localparam int X_W        = 17;
    localparam int INDEX_W    = 4;
    localparam int BASIS_W    = 17;
    localparam int DERIV_W    = 21;
    localparam int DEG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_EN = 1'd1;

    localparam logic [DEG_W-1:0] DEGREE_RST   = 4'd3;
    localparam logic             DERIV_EN_RST = 1'b1;

    localparam logic [31:0]        BASIS_MAX = 32'h0001_FFFF;
    localparam logic signed [63:0] DERIV_HI  = 64'sh0000_0000_000F_FFFF;
    localparam logic signed [63:0] DERIV_LO  = -64'sh0000_0000_0010_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_OUT
    } bbe_state_t;

    // control from the sequencer to the cell row and output stage
    typedef struct packed {
        logic ready;
        logic load;
        logic step;
        logic snap;
        logic shift;
    } bbe_ctl_t;

endpackage

/* rtl/core/bbe_ifs.sv */
// Valid/ready stream interfaces for evaluation points and basis results
interface bbe_point_if import bbe_pkg::*;;
    logic             valid;
    logic             ready;
    logic [X_W-1:0]   x;

    modport source (output valid, output x, input ready);
    modport sink   (input valid, input x, output ready);
endinterface

interface bbe_result_if import bbe_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [INDEX_W-1:0]        index;
    logic [BASIS_W-1:0]        basis_value;
    logic signed [DERIV_W-1:0] derivative_value;
    logic                      last;

    modport source (output valid, output index, output basis_value,
                    output derivative_value, output last, input ready);
    modport sink   (input valid, input index, input basis_value,
                    input derivative_value, input last, output ready);
endinterface

/* rtl/core/bernstein_basis_evaluator_core.sv */
// Top level of the Bernstein basis evaluator
// For each x the core builds the degree-n Bernstein row in a chain of MAX_DEGREE+1 cells,
// one cell per basis index, all cells applying one triangle-recurrence step per cycle with
// their own multiplier, so the row is built in n steps. The degree n-1 row is snapshotted along
// the way for the derivatives. The row then shifts out of cell 0 at one result per cycle,
// while the output register is empty or being read, through a registered output stage.
// A new x is taken as soon as the last result is loaded into the output register. Degree
// and derivative enable are sampled when x is accepted. No clearing pass after reset.
`include "bernstein_basis_evaluator_core_defines.svh"

module bernstein_basis_evaluator_core
    import bbe_pkg::*;
#(
    parameter int MAX_DEGREE = 15,
    parameter int FRAC_BITS  = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bbe_point_if.sink             point,
    bbe_result_if.source          result
);

    localparam int BW  = FRAC_BITS + 1;
    localparam int NW  = $clog2(MAX_DEGREE + 1);
    localparam int DPW = BW + NW + 2;
    localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;

    // configuration
    logic [DEG_W-1:0] degree_reg;
    logic             deriv_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg   <= DEGREE_RST;
            deriv_en_reg <= DERIV_EN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEGREE)
            begin
                degree_reg <= cfg_data[DEG_W-1:0];
            end
            else if (cfg_index == REG_DERIV_EN)
            begin
                deriv_en_reg <= cfg_data[0];
            end
        end
    end

    // per-item operands
    bbe_ctl_t      ctl;
    logic [NW-1:0] count;
    logic [NW-1:0] n_new;
    logic [NW-1:0] n_reg;
    logic          den_reg;
    logic [BW-1:0] x_q_reg;
    logic [31:0]   x_sat;
    logic          slot_free;
    logic          out_valid_reg;

    assign n_new = (32'(degree_reg) > MAX_DEGREE) ? NW'(MAX_DEGREE) : NW'(degree_reg);
    assign x_sat = (32'(point.x) > ONE32) ? ONE32 : 32'(point.x);
    assign slot_free = !out_valid_reg || result.ready;
    assign point.ready = ctl.ready;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            n_reg   <= n_new;
            den_reg <= deriv_en_reg;
            x_q_reg <= BW'(x_sat);
        end
    end

    bbe_ctrl #(
        .MAX_DEGREE (MAX_DEGREE),
        .NW         (NW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .slot_free (slot_free),
        .n_new     (n_new),
        .n_reg     (n_reg),
        .ctl       (ctl),
        .count     (count)
    );

    // cell row
    logic [BW-1:0] b_w [0:MAX_DEGREE];
    logic [BW-1:0] p_w [0:MAX_DEGREE];

    for (genvar r = 0; r <= MAX_DEGREE; r++)
    begin : g_cell
        logic [BW-1:0] b_left_w, b_right_w, p_right_w;

        if (r == 0)
        begin : g_first
            assign b_left_w = '0;
        end
        else
        begin : g_inner_l
            assign b_left_w = b_w[r-1];
        end

        if (r == MAX_DEGREE)
        begin : g_end
            assign b_right_w = '0;
            assign p_right_w = '0;
        end
        else
        begin : g_inner_r
            assign b_right_w = b_w[r+1];
            assign p_right_w = p_w[r+1];
        end

        bbe_cell #(
            .FRAC_BITS (FRAC_BITS),
            .BW        (BW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .init_value ((r == 0) ? BW'(ONE32) : BW'(0)),
            .x_q        (x_q_reg),
            .b_left     (b_left_w),
            .b_right    (b_right_w),
            .p_right    (p_right_w),
            .b_out      (b_w[r]),
            .p_out      (p_w[r])
        );
    end

    // output stage: derivative from the snapshot entry just shifted out and the current one
    logic [BW-1:0]             p_left_reg;
    logic signed [BW:0]        pdiff;
    logic signed [DPW-1:0]     dprod;
    logic signed [63:0]        d_ext;
    logic signed [DERIV_W-1:0] d_sat;
    logic [BASIS_W-1:0]        b_sat;

    logic [INDEX_W-1:0]        index_reg;
    logic [BASIS_W-1:0]        basis_reg;
    logic signed [DERIV_W-1:0] deriv_reg;
    logic                      last_reg;

    always_comb
    begin
        pdiff = $signed({1'b0, p_left_reg}) - $signed({1'b0, p_w[0]});
        dprod = pdiff * $signed({1'b0, n_reg});
        d_ext = 64'(dprod);
        if (!den_reg || (n_reg == '0))
        begin
            d_sat = '0;
        end
        else if (d_ext > DERIV_HI)
        begin
            d_sat = DERIV_W'(DERIV_HI);
        end
        else if (d_ext < DERIV_LO)
        begin
            d_sat = DERIV_W'(DERIV_LO);
        end
        else
        begin
            d_sat = DERIV_W'(d_ext);
        end
        b_sat = (32'(b_w[0]) > BASIS_MAX) ? BASIS_W'(BASIS_MAX) : BASIS_W'(b_w[0]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            p_left_reg <= '0;
        end
        else if (ctl.shift)
        begin
            p_left_reg <= p_w[0];
        end
        if (ctl.shift)
        begin
            index_reg <= INDEX_W'(count);
            basis_reg <= b_sat;
            deriv_reg <= d_sat;
            last_reg  <= (count == n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.index            = index_reg;
    assign result.basis_value      = basis_reg;
    assign result.derivative_value = deriv_reg;
    assign result.last             = last_reg;

    `BBE_ASSERT_NEXT(a_one_item, point.valid && point.ready, !point.ready)
    `BBE_ASSERT_IMPL(a_basis_bound, result.valid, 32'(result.basis_value) <= ONE32)
    `BBE_ASSERT_IMPL(a_ctl_excl, 1'b1, $onehot0({ctl.load, ctl.step, ctl.shift}))

endmodule

/* rtl/core/bbe_cell.sv */
// One cell of the basis row: recurrence step, snapshot and shift-out
module bbe_cell
    import bbe_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int BW        = FRAC_BITS + 1
)(
    input  logic          clk,
    input  bbe_ctl_t      ctl,
    input  logic [BW-1:0] init_value,
    input  logic [BW-1:0] x_q,
    input  logic [BW-1:0] b_left,
    input  logic [BW-1:0] b_right,
    input  logic [BW-1:0] p_right,
    output logic [BW-1:0] b_out,
    output logic [BW-1:0] p_out
);

    localparam int AW = 2 * BW + 2;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);

    logic [BW-1:0] b_reg, b_next;
    logic [BW-1:0] p_reg, p_next;

    logic signed [BW:0]   xs;
    logic signed [BW:0]   diff;
    logic signed [AW-1:0] prod;
    logic signed [AW-1:0] base;
    logic signed [AW-1:0] acc;

    // Y*b + X*bl == (b << F) + X*(bl - b): one multiplier per cell
    always_comb
    begin
        xs   = $signed({1'b0, x_q});
        diff = $signed({1'b0, b_left}) - $signed({1'b0, b_reg});
        prod = xs * diff;
        base = $signed({{(AW - BW){1'b0}}, b_reg}) <<< FRAC_BITS;
        acc  = base + prod + HALF;
    end

    always_comb
    begin
        b_next = b_reg;
        p_next = p_reg;
        if (ctl.load)
        begin
            b_next = init_value;
            p_next = '0;
        end
        else if (ctl.step)
        begin
            b_next = acc[FRAC_BITS +: BW];
            if (ctl.snap)
            begin
                p_next = b_reg;
            end
        end
        else if (ctl.shift)
        begin
            b_next = b_right;
            p_next = p_right;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign b_out = b_reg;
    assign p_out = p_reg;

endmodule

/* rtl/core/bbe_ctrl.sv */
// Sequencer: accept, recurrence steps, then one result per basis index
module bbe_ctrl
    import bbe_pkg::*;
#(
    parameter int MAX_DEGREE = 15,
    parameter int NW         = $clog2(MAX_DEGREE + 1)
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          slot_free,
    input  logic [NW-1:0] n_new,
    input  logic [NW-1:0] n_reg,
    output bbe_ctl_t      ctl,
    output logic [NW-1:0] count
);

    bbe_state_t    state_reg, state_next;
    logic [NW-1:0] count_reg, count_next;
    logic          at_end;

    assign at_end = (count_reg == n_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (n_new == '0)
                    begin
                        state_next = S_OUT;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next = S_CALC;
                        count_next = NW'(1);
                    end
                end
            end
            S_CALC:
            begin
                if (at_end)
                begin
                    state_next = S_OUT;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + NW'(1);
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    if (at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + NW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                count_next = '0;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.ready = 1'b1;
                ctl.load  = in_valid;
            end
            S_CALC:
            begin
                ctl.step = 1'b1;
                ctl.snap = at_end;
            end
            S_OUT:
            begin
                ctl.shift = slot_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule
